### src/deq_pkg.sv
// Shared types and codes for the double-ended queue.
// Request codes, status codes, cell commands and controller states.
// No dependencies.
package deq_pkg;

  localparam int WORD_W = 32;
  localparam int REQ_W  = 3;
  localparam int STAT_W = 2;

  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH_FRONT = 3'd0,
    REQ_PUSH_BACK  = 3'd1,
    REQ_POP_FRONT  = 3'd2,
    REQ_POP_BACK   = 3'd3,
    REQ_CLEAR      = 3'd4,
    REQ_READ_ALL   = 3'd5
  } req_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_SHIFT_RIGHT,
    CELL_LOAD_TAIL,
    CELL_SHIFT_LEFT
  } cell_op_t;

  typedef struct packed {
    cell_op_t           op;
    logic [WORD_W-1:0]  load_word;
  } cell_cmd_t;

  typedef enum logic {
    ST_IDLE,
    ST_STREAM
  } state_t;

endpackage

### src/deq_if.sv
// Valid/ready channel interfaces for the double-ended queue.
// Depends on deq_pkg for field widths.
interface deq_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [deq_pkg::REQ_W-1:0]            req_type;
  logic signed [deq_pkg::WORD_W-1:0]    value;

  modport source (output valid, output req_type, output value, input ready);
  modport sink   (input valid, input req_type, input value, output ready);
endinterface

interface deq_out_if #(
  parameter int OCC_W = 6
);
  logic                                 valid;
  logic                                 ready;
  logic signed [deq_pkg::WORD_W-1:0]    word;
  logic [deq_pkg::STAT_W-1:0]           status;
  logic [OCC_W-1:0]                     occupancy;
  logic                                 last;

  modport source (output valid, output word, output status, output occupancy,
                  output last, input ready);
  modport sink   (input valid, input word, input status, input occupancy,
                  input last, output ready);
endinterface

### src/deq_cell.sv
// One storage cell of the queue chain; holds one word.
// Shifts toward either neighbor or loads at the tail position.
// Depends on deq_pkg.
module deq_cell #(
  parameter int IDX_W = 5,
  parameter int IDX   = 0
) (
  input  logic                           clk,
  input  deq_pkg::cell_cmd_t             cmd,
  input  logic [IDX_W-1:0]               tail_idx,
  input  logic [deq_pkg::WORD_W-1:0]     left_data,
  input  logic [deq_pkg::WORD_W-1:0]     right_data,
  output logic [deq_pkg::WORD_W-1:0]     data
);

  logic [deq_pkg::WORD_W-1:0] data_r;
  logic [deq_pkg::WORD_W-1:0] data_nxt;
  logic                       at_tail;

  assign at_tail = (tail_idx == IDX_W'(IDX));

  always_comb begin
    data_nxt = data_r;
    case (cmd.op)
      deq_pkg::CELL_SHIFT_RIGHT: data_nxt = left_data;
      deq_pkg::CELL_LOAD_TAIL: begin
        if (at_tail) data_nxt = cmd.load_word;
      end
      deq_pkg::CELL_SHIFT_LEFT: begin
        data_nxt = at_tail ? cmd.load_word : right_data;
      end
      default: data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data = data_r;

endmodule

### src/double_ended_queue.sv
// Bounded double-ended queue of signed 32-bit words in a chain of cells.
// Depends on deq_pkg, deq_in_if, deq_out_if and deq_cell.
//
// The queue is a row of DEPTH cells with the front word always in cell 0.
// Push front shifts the row right, pop front shifts it left, push back and
// pop back touch the cell at the tail. Push, pop, clear and unknown codes
// give one beat each. Read-all on an empty queue gives one beat with empty
// status; else it gives one beat per stored word, front to back, at one per
// cycle while the output is not stalled: the row rotates by one cell per
// beat and is back in its original order after the last one. No new request
// is taken until read-all is through. A finished beat holds in the output
// register until it is taken; a new request is taken only while that
// register is empty or its beat leaves in the same cycle.
module double_ended_queue #(
  parameter int DEPTH = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  deq_in_if.sink             in_ch,
  deq_out_if.source          out_ch
);

  localparam int WORD_W = deq_pkg::WORD_W;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int OCC_W  = $clog2(DEPTH + 1);

  deq_pkg::state_t            state_r, state_nxt;
  logic [OCC_W-1:0]           count_r, count_nxt;
  logic [OCC_W-1:0]           remain_r, remain_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic [WORD_W-1:0]          out_word_r, out_word_nxt;
  deq_pkg::status_t           out_status_r, out_status_nxt;
  logic [OCC_W-1:0]           out_occ_r, out_occ_nxt;
  logic                       out_last_r, out_last_nxt;

  deq_pkg::cell_cmd_t         cmd;
  logic [IDX_W-1:0]           tail_idx;
  logic [IDX_W-1:0]           back_idx;
  logic [WORD_W-1:0]          back_word;
  logic [WORD_W-1:0]          cell_data [DEPTH];
  logic                       slot_free;
  logic                       accept;
  logic                       full;
  logic                       empty;

  genvar g;
  generate
    for (g = 0; g < DEPTH; g++) begin : g_cell
      logic [WORD_W-1:0] left_w;
      logic [WORD_W-1:0] right_w;
      if (g == 0) begin : g_first
        assign left_w = in_ch.value;
      end else begin : g_mid_l
        assign left_w = cell_data[g-1];
      end
      if (g == DEPTH - 1) begin : g_last
        assign right_w = '0;
      end else begin : g_mid_r
        assign right_w = cell_data[g+1];
      end
      deq_cell #(
        .IDX_W (IDX_W),
        .IDX   (g)
      ) u_cell (
        .clk        (clk),
        .cmd        (cmd),
        .tail_idx   (tail_idx),
        .left_data  (left_w),
        .right_data (right_w),
        .data       (cell_data[g])
      );
    end
  endgenerate

  assign slot_free   = !out_valid_r || out_ch.ready;
  assign in_ch.ready = (state_r == deq_pkg::ST_IDLE) && slot_free;
  assign accept      = in_ch.valid && in_ch.ready;
  assign full        = (count_r == OCC_W'(DEPTH));
  assign empty       = (count_r == '0);
  assign back_idx    = IDX_W'(count_r - 1'b1);

  always_comb begin
    back_word = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (back_idx == IDX_W'(i)) back_word = back_word | cell_data[i];
    end
  end

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    remain_nxt     = remain_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_word_nxt   = out_word_r;
    out_status_nxt = out_status_r;
    out_occ_nxt    = out_occ_r;
    out_last_nxt   = out_last_r;
    cmd.op         = deq_pkg::CELL_HOLD;
    cmd.load_word  = in_ch.value;
    tail_idx       = back_idx;

    unique case (state_r)
      deq_pkg::ST_IDLE: begin
        if (accept) begin
          out_word_nxt   = '0;
          out_status_nxt = deq_pkg::STAT_OK;
          out_last_nxt   = 1'b1;
          out_valid_nxt  = 1'b1;
          unique case (deq_pkg::req_t'(in_ch.req_type))
            deq_pkg::REQ_PUSH_FRONT: begin
              if (full) begin
                out_status_nxt = deq_pkg::STAT_FULL;
              end else begin
                cmd.op    = deq_pkg::CELL_SHIFT_RIGHT;
                count_nxt = count_r + 1'b1;
              end
            end
            deq_pkg::REQ_PUSH_BACK: begin
              if (full) begin
                out_status_nxt = deq_pkg::STAT_FULL;
              end else begin
                cmd.op    = deq_pkg::CELL_LOAD_TAIL;
                tail_idx  = count_r[IDX_W-1:0];
                count_nxt = count_r + 1'b1;
              end
            end
            deq_pkg::REQ_POP_FRONT: begin
              if (empty) begin
                out_status_nxt = deq_pkg::STAT_EMPTY;
              end else begin
                out_word_nxt = cell_data[0];
                cmd.op       = deq_pkg::CELL_SHIFT_LEFT;
                count_nxt    = count_r - 1'b1;
              end
            end
            deq_pkg::REQ_POP_BACK: begin
              if (empty) begin
                out_status_nxt = deq_pkg::STAT_EMPTY;
              end else begin
                out_word_nxt = back_word;
                count_nxt    = count_r - 1'b1;
              end
            end
            deq_pkg::REQ_CLEAR: begin
              count_nxt = '0;
            end
            deq_pkg::REQ_READ_ALL: begin
              if (empty) begin
                out_status_nxt = deq_pkg::STAT_EMPTY;
              end else begin
                out_valid_nxt = out_valid_r && !out_ch.ready;
                remain_nxt    = count_r;
                state_nxt     = deq_pkg::ST_STREAM;
              end
            end
            default: begin
            end
          endcase
          out_occ_nxt = count_nxt;
        end
      end
      deq_pkg::ST_STREAM: begin
        if (slot_free) begin
          out_valid_nxt  = 1'b1;
          out_word_nxt   = cell_data[0];
          out_status_nxt = deq_pkg::STAT_OK;
          out_occ_nxt    = count_r;
          out_last_nxt   = (remain_r == OCC_W'(1));
          cmd.op         = deq_pkg::CELL_SHIFT_LEFT;
          cmd.load_word  = cell_data[0];
          remain_nxt     = remain_r - 1'b1;
          if (remain_r == OCC_W'(1)) state_nxt = deq_pkg::ST_IDLE;
        end
      end
      default: state_nxt = deq_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= deq_pkg::ST_IDLE;
      count_r     <= '0;
      remain_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      remain_r    <= remain_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_word_r   <= out_word_nxt;
    out_status_r <= out_status_nxt;
    out_occ_r    <= out_occ_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.word      = out_word_r;
  assign out_ch.status    = out_status_r;
  assign out_ch.occupancy = out_occ_r;
  assign out_ch.last      = out_last_r;

endmodule
